// File: rtl/ptsc_pkg.sv
// ptsc_pkg: types and fixed constants for the pump tacho and speed curve block
// depends on nothing; imported by pump_tacho_and_temp_speed_ctrl_top
`default_nettype none

package ptsc_pkg;

  localparam int unsigned MIN_PERIOD = 1000;
  localparam logic [4:0]  IDLE_LIMIT = 5'd30;
  localparam logic [4:0]  IDLE_MAX   = 5'd31;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [15:0] PERIOD_MAX = 16'hffff;
  localparam logic [12:0] DEG_SCALE  = 13'd100;

  // drive = pct * 4095 / 100, division by reciprocal multiply
  localparam logic [11:0] DAC_FULL   = 12'hfff;
  localparam logic [19:0] RECIP_100  = 20'd671089;
  localparam int unsigned RECIP_SH   = 26;

  localparam int unsigned DIV_STEPS  = 12;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CFG_SPEED_LOW  = 2'd0,
    CFG_SPEED_HIGH = 2'd1,
    CFG_TEMP_LOW   = 2'd2,
    CFG_TEMP_HIGH  = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    SEG_LOW,
    SEG_HIGH,
    SEG_MID
  } seg_e;

  function automatic logic [11:0] pct_to_drive(input logic [6:0] pct);
    logic [18:0] scaled;
    logic [38:0] prod;
    begin
      scaled = 19'(pct) * 19'(DAC_FULL);
      prod   = 39'(scaled) * 39'(RECIP_100);
      pct_to_drive = prod[RECIP_SH +: 12];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/pump_tacho_and_temp_speed_ctrl_top.sv
// pump_tacho_and_temp_speed_ctrl_top: tach period and stall tracking, temperature speed curve
// depends on ptsc_pkg
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   capture_value_i, water_temp_i
//   out      source     out_valid_o / out_stall_i pump_drive_o, speed_percent_o,
//                                                 tach_period_o, stalled_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one transaction at a time: the next input is accepted only after the result is
// taken; a temperature between the breakpoints runs the shared restoring divider,
// 12 steps each for percent and drive, one clamped to a breakpoint skips it
// a stalled output holds the result and keeps the input stalled
// reset restores the register defaults and clears the tach state, no clearing pass
`default_nettype none

module pump_tacho_and_temp_speed_ctrl_top
  import ptsc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [15:0]        capture_value_i,
  input  wire logic signed [14:0] water_temp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [11:0]             pump_drive_o,
  output logic [6:0]              speed_percent_o,
  output logic [15:0]             tach_period_o,
  output logic                    stalled_o
);

  localparam int unsigned CW = (TIMER_BITS < 16) ? TIMER_BITS : 16;
  localparam int unsigned DW = (TIMER_BITS > 17) ? TIMER_BITS : 17;
  localparam logic [DW-1:0] TMASK = {DW{1'b1}} >> (DW - TIMER_BITS);

  state_e state_q, state_d;

  logic [6:0] spd_lo_q, spd_hi_q;
  logic [5:0] tmp_lo_q, tmp_hi_q;

  logic [CW-1:0] last_cap_q;
  logic [4:0]    idle_q;
  logic [15:0]   period_q;
  logic          stall_q;

  logic signed [14:0] temp_q;
  seg_e        seg_q;
  logic [12:0] dt_q, span_q;
  logic [6:0]  pl_q, ph_q;
  logic [11:0] dl_q, dh_q;
  logic [24:0] rem_q, ds_q;
  logic [11:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic        drv_phase_q;

  logic [11:0] drive_q;
  logic [6:0]  pct_q;
  logic [15:0] period_out_q;
  logic        stalled_out_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_lo_q <= 7'd30;
      spd_hi_q <= 7'd95;
      tmp_lo_q <= 6'd25;
      tmp_hi_q <= 6'd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED_LOW:  spd_lo_q <= cfg_data_i;
        CFG_SPEED_HIGH: spd_hi_q <= cfg_data_i;
        CFG_TEMP_LOW:   tmp_lo_q <= cfg_data_i[5:0];
        CFG_TEMP_HIGH:  tmp_hi_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // tach period and stall tracking
  logic [CW-1:0] cap_m;
  logic          tach_edge, period_ok;
  logic [DW-1:0] diff;
  logic [15:0]   period_sat, period_d;
  logic [4:0]    idle_d;
  logic          stall_d;

  always_comb begin
    cap_m      = capture_value_i[CW-1:0];
    tach_edge  = cap_m != last_cap_q;
    diff       = (DW'(cap_m) - DW'(last_cap_q)) & TMASK;
    period_sat = (diff > DW'(PERIOD_MAX)) ? PERIOD_MAX : diff[15:0];
    period_ok  = tach_edge && (diff > DW'(MIN_PERIOD)) && (idle_q < IDLE_LIMIT);
    period_d   = period_ok ? period_sat : period_q;
    if (tach_edge) begin
      idle_d = 5'd1;
    end else if (idle_q < IDLE_MAX) begin
      idle_d = idle_q + 5'd1;
    end else begin
      idle_d = idle_q;
    end
    stall_d = (period_ok ? 1'b0 : stall_q) | (idle_d > IDLE_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cap_q <= '0;
      idle_q     <= '0;
      period_q   <= '0;
      stall_q    <= 1'b0;
    end else if (in_acc) begin
      if (tach_edge) begin
        last_cap_q <= cap_m;
      end
      idle_q   <= idle_d;
      period_q <= period_d;
      stall_q  <= stall_d;
    end
  end

  // breakpoints and endpoints
  logic [12:0] tl, th;
  logic signed [15:0] temp16, tl16, th16, dt16;
  logic [6:0]  pl, ph;

  always_comb begin
    tl     = 13'(tmp_lo_q) * DEG_SCALE;
    th     = 13'(tmp_hi_q) * DEG_SCALE;
    temp16 = {temp_q[14], temp_q};
    tl16   = $signed({3'b000, tl});
    th16   = $signed({3'b000, th});
    dt16   = temp16 - tl16;
    pl     = (spd_lo_q > PCT_FULL) ? PCT_FULL : spd_lo_q;
    ph     = (spd_hi_q > PCT_FULL) ? PCT_FULL : spd_hi_q;
  end

  // shared multiplier and divider step
  logic        mul_drv, pct_neg, drv_neg, div_ge, div_last;
  logic [6:0]  pct_mag;
  logic [11:0] drv_mag, mul_a, quo_fin;
  logic [24:0] product;

  always_comb begin
    pct_neg  = ph_q < pl_q;
    drv_neg  = dh_q < dl_q;
    pct_mag  = pct_neg ? (pl_q - ph_q) : (ph_q - pl_q);
    drv_mag  = drv_neg ? (dl_q - dh_q) : (dh_q - dl_q);
    mul_drv  = state_q == S_DIV;
    mul_a    = mul_drv ? drv_mag : {5'b00000, pct_mag};
    product  = {13'b0, mul_a} * {12'b0, dt_q};
    div_ge   = rem_q >= ds_q;
    div_last = cnt_q == CNT_W'(DIV_STEPS - 1);
    quo_fin  = {quo_q[10:0], div_ge};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: state_d = S_LOAD;
      S_LOAD: state_d = (seg_q == SEG_MID) ? S_DIV : S_OUT;
      S_DIV:  if (div_last && drv_phase_q) state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drv_phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD) begin
        cnt_q       <= '0;
        drv_phase_q <= 1'b0;
      end else if (state_q == S_DIV) begin
        if (div_last) begin
          cnt_q       <= '0;
          drv_phase_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          temp_q        <= water_temp_i;
          period_out_q  <= stall_d ? 16'd0 : period_d;
          stalled_out_q <= stall_d;
        end
      end
      S_PREP: begin
        if (temp16 <= tl16) begin
          seg_q <= SEG_LOW;
        end else if (temp16 >= th16) begin
          seg_q <= SEG_HIGH;
        end else begin
          seg_q <= SEG_MID;
        end
        dt_q   <= dt16[12:0];
        span_q <= th - tl;
        pl_q   <= pl;
        ph_q   <= ph;
        dl_q   <= pct_to_drive(pl);
        dh_q   <= pct_to_drive(ph);
      end
      S_LOAD: begin
        if (seg_q == SEG_LOW) begin
          pct_q   <= pl_q;
          drive_q <= dl_q;
        end else if (seg_q == SEG_HIGH) begin
          pct_q   <= ph_q;
          drive_q <= dh_q;
        end
        rem_q <= product;
        ds_q  <= {1'b0, span_q, 11'b0};
        quo_q <= '0;
      end
      S_DIV: begin
        if (div_last) begin
          if (drv_phase_q) begin
            drive_q <= drv_neg ? (dl_q - quo_fin) : (dl_q + quo_fin);
          end else begin
            pct_q <= pct_neg ? (pl_q - quo_fin[6:0]) : (pl_q + quo_fin[6:0]);
            rem_q <= product;
            ds_q  <= {1'b0, span_q, 11'b0};
            quo_q <= '0;
          end
        end else begin
          rem_q <= div_ge ? (rem_q - ds_q) : rem_q;
          ds_q  <= ds_q >> 1;
          quo_q <= quo_fin;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = state_q == S_OUT;
  assign pump_drive_o    = drive_q;
  assign speed_percent_o = pct_q;
  assign tach_period_o   = period_out_q;
  assign stalled_o       = stalled_out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after a transaction");

  a_drop_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_o)
    else $error("result offered twice");

  a_stalled_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stalled_o) |-> (tach_period_o == 16'd0))
    else $error("period shown while stalled");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (speed_percent_o <= PCT_FULL))
    else $error("speed percent above full scale");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

endmodule

`default_nettype wire
